// ===== rtl/mtq_pkg.sv =====
package mtq_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 8;

  localparam int ADDR_W   = 24;
  localparam int TIME_W   = 32;
  localparam int LIMIT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'd1;

  localparam logic [2:0] REQ_ADD        = 3'd0;
  localparam logic [2:0] REQ_FIND_DUE   = 3'd1;
  localparam logic [2:0] REQ_POP_HEAD   = 3'd2;
  localparam logic [2:0] REQ_REM_HANDLE = 3'd3;
  localparam logic [2:0] REQ_REM_ACKED  = 3'd4;
  localparam logic [2:0] REQ_RETIME     = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int FLAG_ACK  = 0;
  localparam int FLAG_WANT = 1;

  typedef struct packed {
    logic load;
    logic decide;
    logic walk;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic dec_walk;
    logic dec_insert;
    logic wk_done;
    logic wk_insert;
  } stat_t;

endpackage

// ===== rtl/mac_tx_queue_engine.sv =====
// Ordered transmit queue of frame descriptors. A request word is taken when
// start is high and busy is low; its single result word appears on the out_
// ports for exactly one cycle, marked by out_valid, and must be captured then,
// as the receiver cannot stall the block. One request is in flight at a time.
// The entry store has one read and one write port, and the controller steps
// through it one entry a cycle while it walks the queue; an add writes its
// entry in a separate insert step after any walk. An acknowledgement add
// that also requests an ACK visits the queue twice (duplicate check, then
// the shift that opens the head slot).
// The store needs no clearing after reset; only held entries are ever used.
module mac_tx_queue_engine
  import mtq_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_req_type,
  input  logic [HANDLE_BITS-1:0] in_frame_handle,
  input  logic                   in_is_ack,
  input  logic                   in_wants_ack,
  input  logic [ADDR_W-1:0]      in_source_addr,
  input  logic [ADDR_W-1:0]      in_dest_addr,
  input  logic [TIME_W-1:0]      in_due_time,
  input  logic [TIME_W-1:0]      in_now_tick,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic                   out_found,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // The controller sequences each request; the datapath holds the store,
  // the walk indices and the result fields.
  cmd_t  cmd;
  stat_t stat;

  mtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mtq_datapath #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_frame_handle (in_frame_handle),
    .in_is_ack       (in_is_ack),
    .in_wants_ack    (in_wants_ack),
    .in_source_addr  (in_source_addr),
    .in_dest_addr    (in_dest_addr),
    .in_due_time     (in_due_time),
    .in_now_tick     (in_now_tick),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .res_status      (out_status),
    .res_found       (out_found),
    .res_handle      (out_handle),
    .res_count       (out_entry_count)
  );

endmodule

// ===== rtl/mtq_ctrl.sv =====
module mtq_ctrl
  import mtq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_WALK   = 5'b00100,
    S_INSERT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.dec_walk) begin
          state_nxt = S_WALK;
        end else if (stat.dec_insert) begin
          state_nxt = S_INSERT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.wk_done) begin
          state_nxt = stat.wk_insert ? S_INSERT : S_DONE;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mtq_datapath.sv =====
module mtq_datapath
  import mtq_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [2:0]             in_req_type,
  input  logic [HANDLE_BITS-1:0] in_frame_handle,
  input  logic                   in_is_ack,
  input  logic                   in_wants_ack,
  input  logic [ADDR_W-1:0]      in_source_addr,
  input  logic [ADDR_W-1:0]      in_dest_addr,
  input  logic [TIME_W-1:0]      in_due_time,
  input  logic [TIME_W-1:0]      in_now_tick,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic [1:0]             res_status,
  output logic                   res_found,
  output logic [HANDLE_BITS-1:0] res_handle,
  output logic [$clog2(CAPACITY+1)-1:0] res_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  // Entry store, one array per field sharing a single write and read port.
  logic [HANDLE_BITS-1:0] mem_h [CAPACITY];
  logic [1:0]             mem_f [CAPACITY];
  logic [ADDR_W-1:0]      mem_s [CAPACITY];
  logic [ADDR_W-1:0]      mem_d [CAPACITY];
  logic [TIME_W-1:0]      mem_t [CAPACITY];

  logic [HANDLE_BITS-1:0] rq_h;
  logic [1:0]             rq_f;
  logic [ADDR_W-1:0]      rq_s, rq_d;
  logic [TIME_W-1:0]      rq_t;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [HANDLE_BITS-1:0] wd_h;
  logic [1:0]             wd_f;
  logic [ADDR_W-1:0]      wd_s, wd_d;
  logic [TIME_W-1:0]      wd_t;

  logic [ADDR_W-1:0]      own_r;
  logic [LIMIT_W-1:0]     limit_r;

  logic [2:0]             op_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic                   ack_r, want_r;
  logic [ADDR_W-1:0]      src_r, dst_r;
  logic [TIME_W-1:0]      due_r, now_r;

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [AW-1:0]          r_r, r_nxt;
  logic [CW-1:0]          w_r, w_nxt;
  logic                   back_r, back_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic [HANDLE_BITS-1:0] oh_r, oh_nxt;

  logic                   full, last, drop;
  logic [CW-1:0]          cnt_m1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_h[wr_addr] <= wd_h;
      mem_f[wr_addr] <= wd_f;
      mem_s[wr_addr] <= wd_s;
      mem_d[wr_addr] <= wd_d;
      mem_t[wr_addr] <= wd_t;
    end
    if (rd_en && (32'(rd_addr) < CAPACITY)) begin
      rq_h <= mem_h[rd_addr];
      rq_f <= mem_f[rd_addr];
      rq_s <= mem_s[rd_addr];
      rq_d <= mem_d[rd_addr];
      rq_t <= mem_t[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= '0;
      limit_r <= LIMIT_RST;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS: own_r   <= cfg_wdata;
          CFG_QUEUE_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_req_type;
      h_r    <= in_frame_handle;
      ack_r  <= in_is_ack;
      want_r <= in_wants_ack;
      src_r  <= in_source_addr;
      dst_r  <= in_dest_addr;
      due_r  <= in_due_time;
      now_r  <= in_now_tick;
    end
    r_r      <= r_nxt;
    w_r      <= w_nxt;
    back_r   <= back_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    oh_r     <= oh_nxt;
  end

  assign cnt_m1 = cnt_r - CW'(1);
  assign full   = (32'(cnt_r) >= CAPACITY) ||
                  (!ack_r && (32'(cnt_r) >= 32'(limit_r)));
  assign last   = back_r ? (r_r == '0) : (CW'(r_r) == cnt_m1);

  always_comb begin
    drop = 1'b0;
    case (op_r)
      REQ_POP_HEAD:   drop = (r_r == '0);
      REQ_REM_HANDLE: drop = (rq_h == h_r) && !found_r;
      REQ_REM_ACKED:  drop = rq_f[FLAG_WANT] && (rq_d == dst_r);
      default:        drop = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    r_nxt      = r_r;
    w_nxt      = w_r;
    back_nxt   = back_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    oh_nxt     = oh_r;
    stat       = '0;
    rd_en      = 1'b0;
    rd_addr    = r_r + AW'(1);
    wr_en      = 1'b0;
    wr_addr    = w_r[AW-1:0];
    wd_h       = rq_h;
    wd_f       = rq_f;
    wd_s       = rq_s;
    wd_d       = rq_d;
    wd_t       = rq_t;

    if (cmd.decide) begin
      status_nxt = ST_NOT_FOUND;
      found_nxt  = 1'b0;
      oh_nxt     = '0;
      r_nxt      = '0;
      w_nxt      = '0;
      back_nxt   = 1'b0;
      rd_addr    = '0;
      if (op_r == REQ_ADD) begin
        status_nxt = ST_OK;
        if (full) begin
          status_nxt = ST_FULL;
        end else if (want_r && (cnt_r != '0)) begin
          stat.dec_walk = 1'b1;
          rd_en         = 1'b1;
        end else if (ack_r && (cnt_r != '0)) begin
          stat.dec_walk = 1'b1;
          back_nxt      = 1'b1;
          r_nxt         = cnt_m1[AW-1:0];
          rd_addr       = cnt_m1[AW-1:0];
          rd_en         = 1'b1;
        end else begin
          stat.dec_insert = 1'b1;
        end
      end else if ((op_r >= REQ_FIND_DUE) && (op_r <= REQ_RETIME) && (cnt_r != '0)) begin
        stat.dec_walk = 1'b1;
        rd_en         = 1'b1;
      end
    end

    if (cmd.walk) begin
      rd_en   = 1'b1;
      r_nxt   = r_r + AW'(1);
      rd_addr = r_r + AW'(1);
      case (op_r)
        REQ_ADD: begin
          if (back_r) begin
            // Shift towards the tail to open the head slot.
            wr_en   = 1'b1;
            wr_addr = r_r + AW'(1);
            r_nxt   = r_r - AW'(1);
            rd_addr = r_r - AW'(1);
            if (last) begin
              stat.wk_done   = 1'b1;
              stat.wk_insert = 1'b1;
            end
          end else if (rq_f[FLAG_WANT] && (rq_s == own_r) && (rq_d == dst_r)) begin
            status_nxt   = ST_DUP;
            stat.wk_done = 1'b1;
          end else if (last) begin
            if (ack_r) begin
              back_nxt = 1'b1;
              r_nxt    = cnt_m1[AW-1:0];
              rd_addr  = cnt_m1[AW-1:0];
            end else begin
              stat.wk_done   = 1'b1;
              stat.wk_insert = 1'b1;
            end
          end
        end
        REQ_FIND_DUE: begin
          if (rq_t < now_r) begin
            status_nxt   = ST_OK;
            found_nxt    = 1'b1;
            oh_nxt       = rq_h;
            stat.wk_done = 1'b1;
          end else if (last) begin
            stat.wk_done = 1'b1;
          end
        end
        REQ_RETIME: begin
          if (rq_h == h_r) begin
            wr_en        = 1'b1;
            wr_addr      = r_r;
            wd_t         = due_r;
            status_nxt   = ST_OK;
            found_nxt    = 1'b1;
            oh_nxt       = h_r;
            stat.wk_done = 1'b1;
          end else if (last) begin
            stat.wk_done = 1'b1;
          end
        end
        default: begin
          // Removal ops compact the kept entries towards the head.
          if (drop) begin
            status_nxt = ST_OK;
            found_nxt  = 1'b1;
            if (op_r == REQ_POP_HEAD) begin
              oh_nxt = rq_h;
            end else if (op_r == REQ_REM_HANDLE) begin
              oh_nxt = h_r;
            end
          end else begin
            wr_en = (w_r != CW'(r_r));
            w_nxt = w_r + CW'(1);
          end
          if (last) begin
            stat.wk_done = 1'b1;
            cnt_nxt      = drop ? w_r : w_r + CW'(1);
          end
        end
      endcase
    end

    if (cmd.insert) begin
      wr_en   = 1'b1;
      wr_addr = ack_r ? '0 : cnt_r[AW-1:0];
      wd_h    = h_r;
      wd_f    = {want_r, ack_r};
      wd_s    = src_r;
      wd_d    = dst_r;
      wd_t    = due_r;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  assign res_status = status_r;
  assign res_found  = found_r;
  assign res_handle = oh_r;
  assign res_count  = cnt_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the transmit queue engine. Request words are queued by the
// stimulus process, driven at falling edges by a driver block with random
// gaps, and each accepted word is run through a behavioural queue model here
// in the testbench. The monitor compares every result word, field by field,
// with the oldest predicted result.
module tb;
  import mtq_pkg::*;

  localparam int CAP      = 16;
  localparam int WD_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  handle;
    logic        is_ack;
    logic        wants_ack;
    logic [23:0] src;
    logic [23:0] dst;
    logic [31:0] due;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] handle;
    logic [4:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_frame_handle = '0;
  logic in_is_ack = 1'b0;
  logic in_wants_ack = 1'b0;
  logic [23:0] in_source_addr = '0;
  logic [23:0] in_dest_addr = '0;
  logic [31:0] in_due_time = '0;
  logic [31:0] in_now_tick = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic out_found;
  logic [7:0] out_handle;
  logic [4:0] out_entry_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mac_tx_queue_engine u_dut (.*);

  always #5 clk = ~clk;

  // Queue model: the copy of the block's entry store and its registers.
  logic [7:0]  q_handle[CAP];
  logic        q_ack[CAP];
  logic        q_want[CAP];
  logic [23:0] q_src[CAP];
  logic [23:0] q_dst[CAP];
  logic [31:0] q_due[CAP];
  int          q_count;
  logic [23:0] m_own_addr;
  logic [4:0]  m_limit;
  logic [23:0] m_own_addr_stim;

  request_t pending_words[$];
  reply_t   expected_replies[$];
  int       fail_count;
  int       idle_cycles;
  int       gap_left;
  int       accepted;
  logic     word_taken = 1'b0;

  // Removes the entry at pos and closes the gap, keeping the order.
  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < q_count; k++) begin
      q_handle[k] = q_handle[k+1];
      q_ack[k] = q_ack[k+1];
      q_want[k] = q_want[k+1];
      q_src[k] = q_src[k+1];
      q_dst[k] = q_dst[k+1];
      q_due[k] = q_due[k+1];
    end
    q_count--;
  endfunction

  function automatic int locate_handle(logic [7:0] h);
    for (int k = 0; k < q_count; k++)
      if (q_handle[k] == h) return k;
    return -1;
  endfunction

  // Applies one request to the queue model and returns the reply it gives.
  function automatic reply_t apply_request(request_t r);
    reply_t rp;
    int pos;
    int at;
    int k;
    rp = '0;
    rp.status = ST_NOT_FOUND;
    case (r.req)
      REQ_ADD: begin
        rp.status = ST_OK;
        if (q_count >= CAP || (!r.is_ack && q_count >= m_limit)) begin
          rp.status = ST_FULL;
        end else if (r.wants_ack) begin
          for (k = 0; k < q_count; k++)
            if (q_want[k] && q_src[k] == m_own_addr && q_dst[k] == r.dst) begin
              rp.status = ST_DUP;
              break;
            end
        end
        if (rp.status == ST_OK) begin
          at = q_count;
          if (r.is_ack) begin
            for (k = q_count; k > 0; k--) begin
              q_handle[k] = q_handle[k-1];
              q_ack[k] = q_ack[k-1];
              q_want[k] = q_want[k-1];
              q_src[k] = q_src[k-1];
              q_dst[k] = q_dst[k-1];
              q_due[k] = q_due[k-1];
            end
            at = 0;
          end
          q_handle[at] = r.handle;
          q_ack[at] = r.is_ack;
          q_want[at] = r.wants_ack;
          q_src[at] = r.src;
          q_dst[at] = r.dst;
          q_due[at] = r.due;
          q_count++;
        end
      end
      REQ_FIND_DUE: begin
        for (k = 0; k < q_count; k++)
          if (q_due[k] < r.now) begin
            rp.status = ST_OK;
            rp.found = 1'b1;
            rp.handle = q_handle[k];
            break;
          end
      end
      REQ_POP_HEAD: begin
        if (q_count > 0) begin
          rp.status = ST_OK;
          rp.found = 1'b1;
          rp.handle = q_handle[0];
          drop_entry(0);
        end
      end
      REQ_REM_HANDLE: begin
        pos = locate_handle(r.handle);
        if (pos >= 0) begin
          rp.status = ST_OK;
          rp.found = 1'b1;
          rp.handle = r.handle;
          drop_entry(pos);
        end
      end
      REQ_REM_ACKED: begin
        k = 0;
        while (k < q_count) begin
          if (q_want[k] && q_dst[k] == r.dst) begin
            drop_entry(k);
            rp.status = ST_OK;
            rp.found = 1'b1;
          end else begin
            k++;
          end
        end
      end
      REQ_RETIME: begin
        pos = locate_handle(r.handle);
        if (pos >= 0) begin
          q_due[pos] = r.due;
          rp.status = ST_OK;
          rp.found = 1'b1;
          rp.handle = r.handle;
        end
      end
      default: ;
    endcase
    rp.count = q_count[4:0];
    return rp;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: takes words from the pending queue at falling edges. A word that
  // is still waiting for acceptance keeps start high; only once it has been
  // taken is a fresh word or an idle gap chosen, so start is assigned once.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || word_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          request_t w;
          w = pending_words.pop_front();
          in_req_type <= w.req;
          in_frame_handle <= w.handle;
          in_is_ack <= w.is_ack;
          in_wants_ack <= w.wants_ack;
          in_source_addr <= w.src;
          in_dest_addr <= w.dst;
          in_due_time <= w.due;
          in_now_tick <= w.now;
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: at each rising edge it records acceptance of a request word,
  // predicts the reply, and checks any result word on the out_ ports.
  always @(posedge clk) begin
    reply_t exp_r;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        expected_replies.push_back(apply_request({in_req_type, in_frame_handle,
          in_is_ack, in_wants_ack, in_source_addr, in_dest_addr,
          in_due_time, in_now_tick}));
        accepted <= accepted + 1;
      end
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_found !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, out_found);
            fail_count++;
          end
          if (out_handle !== exp_r.handle) begin
            $error("out_handle: expected %0d, got %0d", exp_r.handle, out_handle);
            fail_count++;
          end
          if (out_entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count,
                   out_entry_count);
            fail_count++;
          end
        end
      end
      // The watchdog: a long stretch with nothing accepted or answered is a hang.
      if (idle_cycles > WD_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // A small pool of handles and destinations makes matches and duplicates
  // common; the own address is mixed in so that the duplicate check fires.
  logic [7:0]  hpool[8];
  logic [23:0] dpool[4];

  function automatic request_t random_word();
    request_t w;
    int roll;
    w.req = 3'($urandom_range(0, 99) < 40 ? REQ_ADD : $urandom_range(1, 7));
    w.handle = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hpool[$urandom_range(0, 7)];
    w.is_ack = ($urandom_range(0, 4) == 0);
    w.wants_ack = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 9);
    w.src = (roll < 6) ? m_own_addr_stim : 24'($urandom);
    w.dst = ($urandom_range(0, 9) == 0) ? 24'($urandom) : dpool[$urandom_range(0, 3)];
    w.due = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 1000));
    w.now = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 1000));
    return w;
  endfunction

  function automatic request_t word_of(logic [2:0] req, logic [7:0] h, logic ack,
                                       logic want, logic [23:0] s, logic [23:0] d,
                                       logic [31:0] due, logic [31:0] now);
    return {req, h, ack, want, s, d, due, now};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_ADDRESS) m_own_addr = val;
    else m_limit = val[4:0];
  endtask

  // Waits until every queued word has been taken and answered, then lets
  // the block settle before the next register write.
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_replies.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [4:0] limits[4];
    fail_count = 0;
    idle_cycles = 0;
    gap_left = 0;
    accepted = 0;
    q_count = 0;
    m_own_addr = '0;
    m_limit = LIMIT_RST;
    m_own_addr_stim = '0;
    for (int k = 0; k < 8; k++) hpool[k] = 8'($urandom);
    hpool[0] = 8'h00;
    hpool[1] = 8'hFF;
    for (int k = 0; k < 4; k++) dpool[k] = 24'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: empty queue cases, extremes, ACK at
    // the head, duplicate ack request, due search bounds, acked removal.
    pending_words.push_back(word_of(REQ_POP_HEAD, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(word_of(REQ_FIND_DUE, 0, 0, 0, 0, 0, 0, '1));
    pending_words.push_back(word_of(REQ_REM_HANDLE, 8'hFF, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(word_of(REQ_ADD, 8'h00, 0, 1, 0, '1, '1, 0));
    pending_words.push_back(word_of(REQ_ADD, 8'hFF, 0, 1, 0, '1, 0, 0));
    pending_words.push_back(word_of(REQ_ADD, 8'h11, 1, 0, '1, 24'h5, 32'd7, 0));
    pending_words.push_back(word_of(REQ_ADD, 8'h22, 0, 1, '1, 24'h5, 32'd3, 0));
    pending_words.push_back(word_of(REQ_FIND_DUE, 0, 0, 0, 0, 0, 0, 32'd3));
    pending_words.push_back(word_of(REQ_FIND_DUE, 0, 0, 0, 0, 0, 0, 32'd4));
    pending_words.push_back(word_of(REQ_FIND_DUE, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(word_of(REQ_RETIME, 8'hFF, 0, 0, 0, 0, '1, 0));
    pending_words.push_back(word_of(REQ_RETIME, 8'h99, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(word_of(REQ_REM_ACKED, 0, 0, 0, 0, '1, 0, 0));
    pending_words.push_back(word_of(REQ_REM_ACKED, 0, 0, 0, 0, '1, 0, 0));
    pending_words.push_back(word_of(REQ_REM_HANDLE, 8'h22, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(word_of(3'd6, 0, 1, 1, '1, '1, '1, '1));
    pending_words.push_back(word_of(3'd7, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 8; k++)
      pending_words.push_back(word_of(REQ_ADD, 8'(k), 0, 0, 0, 24'(k), 32'(k), 0));
    drain();

    // Random phases across several settings, the extremes among them.
    // The queue is left as it is between phases, so fill levels vary.
    limits = '{5'd1, 5'd16, 5'd0, 5'd31};
    for (int ph = 0; ph < 6; ph++) begin
      m_own_addr_stim = (ph == 1) ? '1 : 24'($urandom);
      write_reg(CFG_OWN_ADDRESS, m_own_addr_stim);
      write_reg(CFG_QUEUE_LIMIT, (ph < 4) ? 24'(limits[ph]) : 24'($urandom_range(1, 16)));
      for (int n = 0; n < 250; n++) pending_words.push_back(random_word());
      drain();
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
